// ----- rtl/brb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer with burst read.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned AvailW = 10;
  localparam int unsigned StartW = 10;
  localparam int unsigned ModeW  = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_ATTACH = 2'd3
  } brb_mode_e;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_BURST = 1'b1
  } brb_back_state_e;

  // Classified read request handed from front to back.
  typedef struct packed {
    logic              status;  // no data: emit one status word
    logic [CountW-1:0] count;
    logic [AvailW-1:0] avail;
  } brb_cmd_info_t;

  typedef struct packed {
    logic              byte_valid;
    logic              last;
    logic [AvailW-1:0] avail;
    logic [ByteW-1:0]  data;
  } brb_result_t;

endpackage

// ----- rtl/brb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/brb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_front
// Accept words, keep both positions, write bytes, classify read requests.
// ----------------------------------------------------------------------------
module brb_front
  import brb_pkg::*;
#(
  parameter int unsigned RING_BYTES = 1024,
  parameter int unsigned MAX_BURST  = 64,
  parameter int unsigned PW         = $clog2(RING_BYTES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [StartW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ModeW-1:0]    in_mode_i,
  input  logic [ByteW-1:0]    in_byte_i,
  input  logic [CountW-1:0]   in_count_i,
  input  logic                drain_busy_i,
  input  logic                cmd_ready_i,
  output logic                cmd_valid_o,
  output logic [PW-1:0]       cmd_addr_o,
  output brb_cmd_info_t       cmd_info_o,
  output logic                wr_en_o,
  output logic [PW-1:0]       wr_addr_o,
  output logic [ByteW-1:0]    wr_data_o
);

  localparam int unsigned CW = ((PW > CountW) ? PW : CountW) + 1;

  brb_mode_e         mode;
  logic [PW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [StartW-1:0] start_q;
  logic [PW-1:0]     diff, avail, wp_next, attach_pos;
  logic [CW-1:0]     count_ext, avail_ext, rp_sum;
  logic              burst_ok, accept;

  assign mode = brb_mode_e'(in_mode_i);

  // Fill level: wrap back into range when write is behind read.
  assign diff  = wp_q - rp_q;
  assign avail = (wp_q < rp_q) ? diff + PW'(RING_BYTES) : diff;

  assign count_ext = CW'(in_count_i);
  assign avail_ext = CW'(avail);
  assign burst_ok  = (in_count_i != '0) && (count_ext <= avail_ext) &&
                     (in_count_i <= CountW'(MAX_BURST));

  assign rp_sum     = CW'(rp_q) + count_ext;
  assign wp_next    = (wp_q == PW'(RING_BYTES - 1)) ? '0 : wp_q + 1'b1;
  assign attach_pos = (32'(start_q) < 32'(RING_BYTES)) ? PW'(start_q) : '0;

  // Hold writes until every queued burst has issued its reads.
  always_comb begin
    unique case (mode)
      MODE_WRITE: in_ready_o = !drain_busy_i;
      MODE_READ:  in_ready_o = cmd_ready_i;
      default:    in_ready_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    if (accept) begin
      unique case (mode)
        MODE_WRITE: wp_d = wp_next;
        MODE_READ: begin
          if (burst_ok) begin
            rp_d = (rp_sum >= CW'(RING_BYTES)) ? PW'(rp_sum - CW'(RING_BYTES))
                                                : PW'(rp_sum);
          end
        end
        MODE_CLEAR: begin
          wp_d = '0;
          rp_d = '0;
        end
        MODE_ATTACH: begin
          wp_d = attach_pos;
          rp_d = attach_pos;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      start_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
    end
  end

  assign cmd_valid_o       = accept && (mode == MODE_READ);
  assign cmd_addr_o        = rp_q;
  assign cmd_info_o.status = !burst_ok;
  assign cmd_info_o.count  = in_count_i;
  assign cmd_info_o.avail  = AvailW'(avail);

  assign wr_en_o   = accept && (mode == MODE_WRITE);
  assign wr_addr_o = wp_q;
  assign wr_data_o = in_byte_i;

endmodule

// ----- rtl/brb_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_cmd_fifo
// Two-entry queue of classified read requests between front and back.
// ----------------------------------------------------------------------------
module brb_cmd_fifo #(
  parameter int unsigned WIDTH = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/brb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_back
// Drain read requests: RAM reads one a cycle while the result buffer has room.
// ----------------------------------------------------------------------------
module brb_back
  import brb_pkg::*;
#(
  parameter int unsigned RING_BYTES = 1024,
  parameter int unsigned PW         = $clog2(RING_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  logic [PW-1:0]    cmd_addr_i,
  input  brb_cmd_info_t    cmd_info_i,
  output logic             busy_o,
  output logic             rd_en_o,
  output logic [PW-1:0]    rd_addr_o,
  input  logic [ByteW-1:0] rd_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output brb_result_t      out_o
);

  brb_back_state_e   state_q, state_d;
  logic [PW-1:0]     addr_q, addr_d;
  logic [CountW-1:0] left_q, left_d;
  logic [AvailW-1:0] avail_q, avail_d;
  logic              pend_q, issue;
  brb_result_t       pend_meta_q, meta;
  brb_result_t       pend_word;
  brb_result_t       ent_q [2];
  logic              ow_q, or_q;
  logic [1:0]        occ_q;
  logic              pop_out, can_issue;
  logic [2:0]        fill;

  function automatic logic [PW-1:0] next_addr(input logic [PW-1:0] a);
    return (a == PW'(RING_BYTES - 1)) ? '0 : a + 1'b1;
  endfunction

  assign pop_out   = out_valid_o && out_ready_i;
  // Words buffered plus one in flight must fit the two output slots.
  assign fill      = 3'(occ_q) + 3'(pend_q) - 3'(pop_out);
  assign can_issue = (fill < 3'd2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && can_issue && !cmd_info_i.status &&
            (cmd_info_i.count != CountW'(1))) begin
          state_d = BK_BURST;
        end
      end
      BK_BURST: begin
        if (can_issue && (left_q == CountW'(1))) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    issue       = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = addr_q;
    meta        = '0;
    addr_d      = addr_q;
    left_d      = left_q;
    avail_d     = avail_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && can_issue) begin
          cmd_ready_o     = 1'b1;
          issue           = 1'b1;
          meta.avail      = cmd_info_i.avail;
          meta.byte_valid = !cmd_info_i.status;
          meta.last       = cmd_info_i.status || (cmd_info_i.count == CountW'(1));
          if (!cmd_info_i.status) begin
            rd_en_o   = 1'b1;
            rd_addr_o = cmd_addr_i;
            addr_d    = next_addr(cmd_addr_i);
            left_d    = cmd_info_i.count - 1'b1;
            avail_d   = cmd_info_i.avail;
          end
        end
      end
      BK_BURST: begin
        if (can_issue) begin
          issue           = 1'b1;
          rd_en_o         = 1'b1;
          meta.avail      = avail_q;
          meta.byte_valid = 1'b1;
          meta.last       = (left_q == CountW'(1));
          addr_d          = next_addr(addr_q);
          left_d          = left_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Merge the RAM byte into the word in flight; status words carry zero.
  always_comb begin
    pend_word      = pend_meta_q;
    pend_word.data = pend_meta_q.byte_valid ? rd_data_i : '0;
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    avail_q     <= avail_d;
    pend_meta_q <= meta;
    if (pend_q) begin
      ent_q[ow_q] <= pend_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      left_q  <= '0;
      pend_q  <= 1'b0;
      ow_q    <= 1'b0;
      or_q    <= 1'b0;
      occ_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      pend_q  <= issue;
      if (pend_q) begin
        ow_q <= !ow_q;
      end
      if (pop_out) begin
        or_q <= !or_q;
      end
      occ_q <= occ_q + 2'(pend_q) - 2'(pop_out);
    end
  end

  assign busy_o      = (state_q == BK_BURST);
  assign out_valid_o = (occ_q != 2'd0);
  assign out_o       = ent_q[or_q];

endmodule

// ----- rtl/byte_ring_buffer_burst_read.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_read
// Circular byte store: byte writes, burst reads with status, clear, attach.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tuser mode, tdata byte+count
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata byte+available,
//                                                tuser byte_valid, tlast
//   cfg       in   cfg_we_i (no wait)            cfg_wdata_i start position
//
// A read of n bytes gives n words at one per cycle while the output is not
// stalled, passing through the request queue, the registered RAM read and the
// output buffer; a rejected read gives one status word by the same path. A
// write waits while queued bursts have reads left. Reset zeroes both positions
// and the start position, not the store. Output stalls back up through the
// two-word buffer into the two-entry request queue.
//
module byte_ring_buffer_burst_read
  import brb_pkg::*;
#(
  parameter int unsigned RING_BYTES = 1024,
  parameter int unsigned MAX_BURST  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [StartW-1:0] cfg_wdata_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [7:0] write_byte, [14:8] read_count
  input  logic [1:0]        s_axis_tuser,   // [1:0] mode
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [7:0] out_byte, [17:8] available
  output logic              m_axis_tuser,   // [0] byte_valid
  output logic              m_axis_tlast
);

  localparam int unsigned PW    = $clog2(RING_BYTES);
  localparam int unsigned CMD_W = PW + $bits(brb_cmd_info_t);

  // front -> queue
  logic             cmd_push, cmd_fifo_ready;
  logic [PW-1:0]    cmd_addr_f;
  brb_cmd_info_t    cmd_info_f;
  // queue -> back
  logic             cmd_valid, cmd_pop;
  logic [CMD_W-1:0] cmd_data;
  logic [PW-1:0]    cmd_addr_b;
  brb_cmd_info_t    cmd_info_b;
  // memory ports
  logic             wr_en, rd_en;
  logic [PW-1:0]    wr_addr, rd_addr;
  logic [ByteW-1:0] wr_data, rd_data;
  // status
  logic             bk_busy, drain_busy;
  brb_result_t      result;

  // Writes must wait until no burst still has RAM reads left to issue.
  assign drain_busy = bk_busy || cmd_valid;

  brb_front #(
    .RING_BYTES (RING_BYTES),
    .MAX_BURST  (MAX_BURST),
    .PW         (PW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tuser),
    .in_byte_i    (s_axis_tdata[7:0]),
    .in_count_i   (s_axis_tdata[14:8]),
    .drain_busy_i (drain_busy),
    .cmd_ready_i  (cmd_fifo_ready),
    .cmd_valid_o  (cmd_push),
    .cmd_addr_o   (cmd_addr_f),
    .cmd_info_o   (cmd_info_f),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  brb_cmd_fifo #(
    .WIDTH (CMD_W)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i ({cmd_addr_f, cmd_info_f}),
    .ready_o     (cmd_fifo_ready),
    .pop_i       (cmd_pop),
    .valid_o     (cmd_valid),
    .data_o      (cmd_data)
  );

  assign cmd_addr_b = cmd_data[CMD_W-1 -: PW];
  assign cmd_info_b = brb_cmd_info_t'(cmd_data[$bits(brb_cmd_info_t)-1:0]);

  brb_ram #(
    .WIDTH (ByteW),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  brb_back #(
    .RING_BYTES (RING_BYTES),
    .PW         (PW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_pop),
    .cmd_addr_i  (cmd_addr_b),
    .cmd_info_i  (cmd_info_b),
    .busy_o      (bk_busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  // Pack the result word; pad the upper tdata bits with zeros.
  assign m_axis_tdata = {6'b0, result.avail, result.data};
  assign m_axis_tuser = result.byte_valid;
  assign m_axis_tlast = result.last;

  // A byte write never lands while a burst still has reads to issue.
  a_write_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (!bk_busy && !cmd_valid))
    else $error("byte write overlaps a pending burst read");

  // The front only hands over a request when the queue has room.
  a_queue_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> cmd_fifo_ready)
    else $error("request queue overflow");

  // A status word closes its request and carries a zero byte.
  a_status_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'd0)))
    else $error("malformed status word");

  // A read is issued only when a request is popped or a burst runs.
  a_read_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (bk_busy || cmd_pop))
    else $error("RAM read without an active request");

endmodule

// ----- test/tb_byte_ring_buffer_burst_read.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_burst_read
// Self-checking bench for the circular byte store with burst reads.
// A short directed sequence covers the edge cases: empty-store reads, zero
// counts, counts above the fill level and above the burst limit, clear,
// attach and position wrap. Random traffic follows, mostly write runs closed
// by reads that fit, with some malformed reads, clears, attaches and noise.
// Both stream sides stall at random. An in-bench model of the store predicts
// every output word, and output words are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_burst_read
  import brb_pkg::*;
();

  localparam int unsigned RING_BYTES     = 1024;
  localparam int unsigned MAX_BURST      = 64;
  localparam int unsigned SETTLE_CYCLES  = 8;     // pipeline flush before a config write
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int unsigned LONG_HOLD      = 400;   // one long output back-pressure
  localparam int unsigned HOLD_AFTER     = 90;    // words seen before the long hold
  localparam int unsigned RANDOM_ITEMS   = 150;
  localparam int unsigned PHASES         = 4;
  localparam int unsigned DIR_ROWS       = 23;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [StartW-1:0] cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [7:0] write_byte, [14:8] read_count
  logic [1:0]        s_axis_tuser;   // [1:0] mode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [23:0]       m_axis_tdata;   // [7:0] out_byte, [17:8] available
  logic              m_axis_tuser;   // [0] byte_valid
  logic              m_axis_tlast;

  byte_ring_buffer_burst_read #(
    .RING_BYTES(RING_BYTES),
    .MAX_BURST (MAX_BURST)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Store model: own copy of the byte array, both positions and the start
  // position register.
  // --------------------------------------------------------------------------
  logic [ByteW-1:0]  ring_mem [RING_BYTES];
  int unsigned       wr_pos;
  int unsigned       rd_pos;
  logic [StartW-1:0] start_reg;

  brb_result_t owed_words  [$];  // words the block still owes, oldest first
  brb_result_t burst_words [$];  // words caused by the latest accepted item

  int  error_count = 0;
  int  words_seen  = 0;
  int  stall_cycles = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  bit  long_hold_done = 1'b0;

  function automatic int unsigned step_pos(int unsigned p);
    return (p + 1 >= RING_BYTES) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ring_fill();
    return (wr_pos + RING_BYTES - rd_pos) % RING_BYTES;
  endfunction

  // Status-only word: no data, last set, current fill level.
  function automatic brb_result_t status_word(int unsigned fill);
    brb_result_t w;
    w.byte_valid = 1'b0;
    w.last       = 1'b1;
    w.avail      = AvailW'(fill);
    w.data       = '0;
    return w;
  endfunction

  // Advance the model by one accepted word; collect the output words it causes.
  task automatic ring_predict(brb_mode_e mode, logic [ByteW-1:0] wbyte,
                              logic [CountW-1:0] count);
    int unsigned fill;
    int unsigned attach_pos;
    brb_result_t w;
    burst_words.delete();
    case (mode)
      MODE_WRITE: begin
        ring_mem[wr_pos] = wbyte;
        wr_pos = step_pos(wr_pos);
      end
      MODE_CLEAR: begin
        wr_pos = 0;
        rd_pos = 0;
      end
      MODE_ATTACH: begin
        // a start beyond the store snaps both positions to zero
        attach_pos = (start_reg < RING_BYTES) ? start_reg : 0;
        wr_pos = attach_pos;
        rd_pos = attach_pos;
      end
      default: begin
        fill = ring_fill();
        if (count == 0 || count > fill || count > MAX_BURST) begin
          burst_words.push_back(status_word(fill));
        end else begin
          for (int i = 0; i < count; i++) begin
            w.byte_valid = 1'b1;
            w.last       = (i == count - 1);
            w.avail      = AvailW'(fill);
            w.data       = ring_mem[rd_pos];
            burst_words.push_back(w);
            rd_pos = step_pos(rd_pos);
          end
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one word after a random gap, hold it until accepted, then predict.
  // A typed row replaces the predicted status word with the one in the row.
  task automatic send_item(brb_mode_e mode, logic [ByteW-1:0] wbyte,
                           logic [CountW-1:0] count, logic typed, brb_result_t want);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, count, wbyte};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    ring_predict(mode, wbyte, count);
    if (typed) begin
      owed_words.push_back(want);
    end else begin
      foreach (burst_words[i]) owed_words.push_back(burst_words[i]);
    end
  endtask

  task automatic send_word(brb_mode_e mode, logic [ByteW-1:0] wbyte,
                           logic [CountW-1:0] count);
    send_item(mode, wbyte, count, 1'b0, status_word(0));
  endtask

  // Drop valid, wait until every owed word has come, then let writes settle.
  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start(logic [StartW-1:0] value);
    go_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    start_reg = value;
  endtask

  // Random traffic: mostly write runs closed by a read that fits.
  task automatic run_random(int unsigned n_items, bit do_pause);
    int unsigned issued;
    int unsigned pick;
    int unsigned k;
    int unsigned fill;
    int unsigned cnt;
    bit          paused;
    issued = 0;
    paused = 1'b0;
    while (issued < n_items) begin
      if (do_pause && !paused && issued >= n_items / 2) begin
        // hold the sender until the output side has caught up
        paused = 1'b1;
        go_idle();
      end
      pick = $urandom_range(0, 99);
      fill = ring_fill();
      if (pick < 60) begin
        k = $urandom_range(1, 24);
        repeat (k) send_word(MODE_WRITE, 8'($urandom_range(0, 255)),
                             7'($urandom_range(0, 127)));
        fill = ring_fill();
        cnt = (fill == 0) ? 0 : $urandom_range(1, (fill < MAX_BURST) ? fill : MAX_BURST);
        send_word(MODE_READ, 8'($urandom_range(0, 255)), 7'(cnt));
        issued += k + 1;
      end else if (pick < 75) begin
        cnt = (fill == 0) ? $urandom_range(0, 127)
                          : $urandom_range(1, (fill < MAX_BURST) ? fill : MAX_BURST);
        send_word(MODE_READ, 8'($urandom_range(0, 255)), 7'(cnt));
        issued++;
      end else if (pick < 85) begin
        // malformed read: zero count, more than stored, or over the burst limit
        case ($urandom_range(0, 2))
          0:       cnt = 0;
          1:       cnt = (fill < 127) ? $urandom_range(fill + 1, 127) : $urandom_range(65, 127);
          default: cnt = $urandom_range(MAX_BURST + 1, 127);
        endcase
        send_word(MODE_READ, 8'($urandom_range(0, 255)), 7'(cnt));
        issued++;
      end else if (pick < 92) begin
        send_word(MODE_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        issued++;
      end else if (pick < 98) begin
        send_word(MODE_ATTACH, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        issued++;
      end else begin
        // noise: any mode, any field values
        send_word(brb_mode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  7'($urandom_range(0, 127)));
        issued++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed rows
  // --------------------------------------------------------------------------
  typedef struct {
    logic              do_cfg;   // write the start position instead of a word
    logic [StartW-1:0] cfg_val;
    brb_mode_e         mode;
    logic [ByteW-1:0]  wbyte;    // incremented on each repeat
    logic [CountW-1:0] count;
    int unsigned       reps;
    logic              typed;    // status word given in the row
    int unsigned       avail;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS];

  function automatic dir_row_t mk_row(logic do_cfg, logic [StartW-1:0] cfg_val,
                                      brb_mode_e mode, logic [ByteW-1:0] wbyte,
                                      logic [CountW-1:0] count, int unsigned reps,
                                      logic typed, int unsigned avail);
    dir_row_t r;
    r.do_cfg = do_cfg;  r.cfg_val = cfg_val;  r.mode  = mode;
    r.wbyte  = wbyte;   r.count   = count;    r.reps  = reps;
    r.typed  = typed;   r.avail   = avail;
    return r;
  endfunction

  initial begin
    // empty store right after reset
    dir_rows[0]  = mk_row(0, 0,    MODE_READ,   8'h00, 7'd0,   1,  1, 0);
    dir_rows[1]  = mk_row(0, 0,    MODE_READ,   8'h00, 7'd1,   1,  1, 0);
    dir_rows[2]  = mk_row(0, 0,    MODE_READ,   8'hFF, 7'd127, 1,  1, 0);
    // byte extremes, then enough to exceed the burst limit
    dir_rows[3]  = mk_row(0, 0,    MODE_WRITE,  8'h00, 7'd0,   1,  0, 0);
    dir_rows[4]  = mk_row(0, 0,    MODE_WRITE,  8'hFF, 7'd127, 1,  0, 0);
    dir_rows[5]  = mk_row(0, 0,    MODE_WRITE,  8'h01, 7'd0,   68, 0, 0);
    dir_rows[6]  = mk_row(0, 0,    MODE_READ,   8'h00, 7'd71,  1,  1, 70);
    dir_rows[7]  = mk_row(0, 0,    MODE_READ,   8'h00, 7'd65,  1,  1, 70);
    dir_rows[8]  = mk_row(0, 0,    MODE_READ,   8'h00, 7'd64,  1,  0, 0);
    dir_rows[9]  = mk_row(0, 0,    MODE_READ,   8'h00, 7'd6,   1,  0, 0);
    dir_rows[10] = mk_row(0, 0,    MODE_READ,   8'h00, 7'd1,   1,  1, 0);
    // clear drops unread bytes
    dir_rows[11] = mk_row(0, 0,    MODE_WRITE,  8'hAA, 7'd0,   3,  0, 0);
    dir_rows[12] = mk_row(0, 0,    MODE_CLEAR,  8'h00, 7'd0,   1,  0, 0);
    dir_rows[13] = mk_row(0, 0,    MODE_READ,   8'h00, 7'd1,   1,  1, 0);
    dir_rows[14] = mk_row(0, 0,    MODE_ATTACH, 8'h00, 7'd0,   1,  0, 0);
    // attach at the top of the store and wrap both positions
    dir_rows[15] = mk_row(1, 1023, MODE_WRITE,  8'h00, 7'd0,   1,  0, 0);
    dir_rows[16] = mk_row(0, 0,    MODE_ATTACH, 8'h00, 7'd0,   1,  0, 0);
    dir_rows[17] = mk_row(0, 0,    MODE_WRITE,  8'h5A, 7'd0,   4,  0, 0);
    dir_rows[18] = mk_row(0, 0,    MODE_READ,   8'h00, 7'd4,   1,  0, 0);
    dir_rows[19] = mk_row(0, 0,    MODE_WRITE,  8'h3C, 7'd0,   2,  0, 0);
    dir_rows[20] = mk_row(0, 0,    MODE_ATTACH, 8'h00, 7'd0,   1,  0, 0);
    dir_rows[21] = mk_row(0, 0,    MODE_READ,   8'h00, 7'd2,   1,  1, 0);
    dir_rows[22] = mk_row(1, 0,    MODE_WRITE,  8'h00, 7'd0,   1,  0, 0);
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [StartW-1:0] phase_start [PHASES];
    // drive every input to a known value from time zero
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    wr_pos        = 0;
    rd_pos        = 0;
    start_reg     = '0;
    foreach (ring_mem[i]) ring_mem[i] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) begin
        write_start(dir_rows[i].cfg_val);
      end else begin
        for (int r = 0; r < dir_rows[i].reps; r++) begin
          send_item(dir_rows[i].mode, dir_rows[i].wbyte + 8'(r), dir_rows[i].count,
                    dir_rows[i].typed, status_word(dir_rows[i].avail));
        end
      end
    end

    // random phases, each under its own start position
    phase_start[0] = '0;
    phase_start[1] = 10'd1023;
    phase_start[2] = StartW'($urandom_range(0, 1023));
    phase_start[3] = StartW'($urandom_range(1000, 1023));
    for (int p = 0; p < PHASES; p++) begin
      write_start(phase_start[p]);
      run_random(RANDOM_ITEMS / PHASES, p == 0);
    end

    go_idle();
    if (owed_words.size() != 0) begin
      $display("%0t: %0d output words never arrived", $time, owed_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random ready gaps, one long hold-off to back the block up
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_hold_done && words_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        repeat (LONG_HOLD) begin
          m_axis_tready <= 1'b0;
          @(posedge clk_i);
        end
      end
      if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Compare each accepted output word with the oldest owed word.
  always @(posedge clk_i) begin
    brb_result_t got;
    brb_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      got.byte_valid = m_axis_tuser;
      got.last       = m_axis_tlast;
      got.avail      = m_axis_tdata[17:8];
      got.data       = m_axis_tdata[7:0];
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, got);
        error_count++;
      end else begin
        want = owed_words.pop_front();
        if (got.data !== want.data) begin
          $display("%0t: out_byte expected %0h actual %0h", $time, want.data, got.data);
          error_count++;
        end
        if (got.avail !== want.avail) begin
          $display("%0t: available expected %0d actual %0d", $time, want.avail, got.avail);
          error_count++;
        end
        if (got.byte_valid !== want.byte_valid) begin
          $display("%0t: byte_valid expected %0b actual %0b", $time,
                   want.byte_valid, got.byte_valid);
          error_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
